// File: rtl/integer_to_radix_digits_defines.svh
// Assertion macros for the integer to radix digits block.
// Each macro samples on clk and holds off while rst_n is low.
`ifndef INTEGER_TO_RADIX_DIGITS_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGITS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITRD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ITRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/itrd_pkg.sv
// Shared constants, types and the digit to ASCII mapping for the radix
// conversion block. No dependencies.
package itrd_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = 32;

    localparam int ADDR_W     = $clog2(MAX_DIGITS);
    localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);
    localparam int STEP_W     = $clog2(VALUE_WIDTH);
    localparam int DIGIT_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int RADIX_W    = 6;
    localparam int LIMIT_W    = VALUE_WIDTH - 1;
    localparam int CFG_DATA_W = LIMIT_W;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = LIMIT_W'(1000000);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;

    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
    localparam logic [CHAR_W-1:0]  LETTER_OFS = 7'd10;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {1'b0, d};
        if (d > DIGIT_NINE)
            return d_ext - LETTER_OFS + (upper ? CHAR_UPPER : CHAR_LOWER);
        return d_ext + CHAR_ZERO;
    endfunction

endpackage

// File: rtl/itrd_ram.sv
// Generic single write port RAM with registered read.
// No package dependencies.
module itrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/itrd_div.sv
// Bit-serial restoring divider: unsigned value by a small radix, one
// quotient bit per cycle. Depends on itrd_pkg.
module itrd_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [itrd_pkg::VALUE_WIDTH-1:0]     dividend,
    input  logic [itrd_pkg::RADIX_W-1:0]         divisor,
    output logic [itrd_pkg::VALUE_WIDTH-1:0]     quotient,
    output logic [itrd_pkg::DIGIT_W-1:0]         remainder,
    output itrd_pkg::div_status_t                status
);

    logic [itrd_pkg::VALUE_WIDTH-1:0] q_reg;
    logic [itrd_pkg::DIGIT_W-1:0]     r_reg;
    logic [itrd_pkg::STEP_W-1:0]      step_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic [itrd_pkg::DIGIT_W:0]       trial;
    logic [itrd_pkg::DIGIT_W:0]       diff;
    logic                             ge;

    assign trial = {r_reg, q_reg[itrd_pkg::VALUE_WIDTH-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == itrd_pkg::STEP_W'(itrd_pkg::VALUE_WIDTH - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[itrd_pkg::VALUE_WIDTH-2:0], ge};
            r_reg <= ge ? diff[itrd_pkg::DIGIT_W-1:0] : trial[itrd_pkg::DIGIT_W-1:0];
        end
    end

    assign quotient    = q_reg;
    assign remainder   = r_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: rtl/integer_to_radix_digits.sv
// Top level: signed integer to ASCII digits in a configurable radix.
// Depends on itrd_pkg, itrd_div, itrd_ram and the defines header.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_stall   value
//   out      from block out_valid / out_stall character, digit_count,
//                                             is_negative, status, last
//   cfg      to block   cfg_write             cfg_index, cfg_data
//
// Each digit comes from the bit-serial divider, one quotient bit per cycle.
// An out of range value is loaded as a single status result from S_START once the output register is free.
// in_stall stays high from the transfer until the last result is loaded.
// out_stall holds the output register and pauses the emit sequence.
// Reset clears control state; the digit RAM holds no reset value.
`include "integer_to_radix_digits_defines.svh"

module integer_to_radix_digits (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [itrd_pkg::VALUE_WIDTH-1:0] value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [itrd_pkg::CHAR_W-1:0]          character,
    output logic [itrd_pkg::COUNT_W-1:0]         digit_count,
    output logic                                 is_negative,
    output logic                                 status,
    output logic                                 last,
    input  logic                                 cfg_write,
    input  logic [itrd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [itrd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic [itrd_pkg::RADIX_W-1:0] radix_reg;
    logic                         upper_reg;
    logic [itrd_pkg::LIMIT_W-1:0] limit_reg;

    logic [itrd_pkg::VALUE_WIDTH-1:0] quotient_reg;
    logic [itrd_pkg::COUNT_W-1:0]     count_reg;
    logic [itrd_pkg::COUNT_W-1:0]     count_next;
    logic [itrd_pkg::ADDR_W-1:0]      idx_reg;
    logic                             neg_reg;
    logic                             oor_reg;

    logic                             out_valid_reg;
    logic [itrd_pkg::CHAR_W-1:0]      char_reg;
    logic [itrd_pkg::COUNT_W-1:0]     cnt_out_reg;
    logic                             neg_out_reg;
    logic                             status_reg;
    logic                             last_reg;

    logic [itrd_pkg::RADIX_W-1:0]     base;
    logic                             in_xfer;
    logic                             slot_free;
    logic                             load;
    logic [itrd_pkg::CHAR_W-1:0]      ld_char;
    logic                             ld_neg;
    logic                             ld_status;
    logic                             ld_last;
    logic                             div_start;
    logic                             div_stop;
    logic [itrd_pkg::VALUE_WIDTH-1:0] div_dividend;
    logic [itrd_pkg::VALUE_WIDTH-1:0] div_quot;
    logic [itrd_pkg::DIGIT_W-1:0]     div_rem;
    itrd_pkg::div_status_t            div_stat;
    logic [itrd_pkg::DIGIT_W-1:0]     ram_rdata;

    assign base = (radix_reg < itrd_pkg::RADIX_MIN || radix_reg > itrd_pkg::RADIX_MAX)
                  ? itrd_pkg::RADIX_DEFAULT : radix_reg;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_xfer    = in_valid && !in_stall;
    assign slot_free  = !out_valid_reg || !out_stall;
    assign count_next = count_reg + 1'b1;
    assign div_stop   = (div_quot == '0)
                        || (count_next == itrd_pkg::COUNT_W'(itrd_pkg::MAX_DIGITS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= itrd_pkg::RADIX_DEFAULT;
            upper_reg <= 1'b0;
            limit_reg <= itrd_pkg::LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                itrd_pkg::REG_RADIX: radix_reg <= cfg_data[itrd_pkg::RADIX_W-1:0];
                itrd_pkg::REG_UPPER: upper_reg <= cfg_data[0];
                itrd_pkg::REG_LIMIT: limit_reg <= cfg_data[itrd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        load         = 1'b0;
        ld_char      = itrd_pkg::CHAR_NONE;
        ld_neg       = neg_reg;
        ld_status    = 1'b0;
        ld_last      = 1'b0;
        div_start    = 1'b0;
        div_dividend = quotient_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (oor_reg)
                begin
                    if (slot_free)
                    begin
                        load       = 1'b1;
                        ld_neg     = 1'b0;
                        ld_status  = 1'b1;
                        ld_last    = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    if (div_stop)
                    begin
                        state_next = S_SIGN;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = div_quot;
                    end
                end
            end
            S_SIGN:
            begin
                if (!neg_reg)
                begin
                    state_next = S_READ;
                end
                else if (slot_free)
                begin
                    load       = 1'b1;
                    ld_char    = itrd_pkg::CHAR_MINUS;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    ld_char    = itrd_pkg::digit_char(ram_rdata, upper_reg);
                    ld_last    = (idx_reg == '0);
                    state_next = (idx_reg == '0) ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            quotient_reg  <= '0;
            count_reg     <= '0;
            neg_reg       <= 1'b0;
            oor_reg       <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_xfer)
            begin
                neg_reg      <= value[itrd_pkg::VALUE_WIDTH-1];
                oor_reg      <= !value[itrd_pkg::VALUE_WIDTH-1]
                                && (value[itrd_pkg::VALUE_WIDTH-2:0] > limit_reg);
                quotient_reg <= value[itrd_pkg::VALUE_WIDTH-1]
                                ? (~value + 1'b1) : value;
                count_reg    <= '0;
            end
            else if (state_reg == S_DIV && div_stat.done)
            begin
                quotient_reg <= div_quot;
                count_reg    <= count_next;
                if (div_stop)
                begin
                    idx_reg <= count_reg[itrd_pkg::ADDR_W-1:0];
                end
            end
            else if (state_reg == S_EMIT && slot_free && idx_reg != '0)
            begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg    <= ld_char;
            cnt_out_reg <= ld_status ? '0 : count_reg;
            neg_out_reg <= ld_neg;
            status_reg  <= ld_status;
            last_reg    <= ld_last;
        end
    end

    itrd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (base),
        .quotient  (div_quot),
        .remainder (div_rem),
        .status    (div_stat)
    );

    itrd_ram #(
        .WIDTH (itrd_pkg::DIGIT_W),
        .DEPTH (itrd_pkg::MAX_DIGITS)
    ) u_digits (
        .clk   (clk),
        .we    (state_reg == S_DIV && div_stat.done),
        .waddr (count_reg[itrd_pkg::ADDR_W-1:0]),
        .wdata (div_rem),
        .re    (state_reg == S_READ),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign character   = char_reg;
    assign digit_count = cnt_out_reg;
    assign is_negative = neg_out_reg;
    assign status      = status_reg;
    assign last        = last_reg;

    `ITRD_ASSERT_SAME(a_div_start_idle, div_start, !div_stat.busy,
                      "divider restarted while busy")
    `ITRD_ASSERT_SAME(a_oor_shape, out_valid && status,
                      last && character == itrd_pkg::CHAR_NONE && digit_count == '0,
                      "malformed out of range result")
    `ITRD_ASSERT_SAME(a_last_is_digit, out_valid && last && !status,
                      character != itrd_pkg::CHAR_MINUS && digit_count != '0,
                      "last result is not a digit")
    `ITRD_ASSERT_NEXT(a_emit_follows_read, state_reg == S_READ, state_reg == S_EMIT,
                      "read not followed by emit")

endmodule

// File: tb/itrd_digit_checker.sv
// Checker for integer_to_radix_digits: tracks register writes, predicts the
// characters of each accepted value and compares every output transfer.
// Depends on itrd_pkg.
module itrd_digit_checker
    import itrd_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [CHAR_W-1:0]             character,
    input  logic [COUNT_W-1:0]            digit_count,
    input  logic                          is_negative,
    input  logic                          status,
    input  logic                          last,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output int                            errors,
    output int                            pending
);

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [COUNT_W-1:0] count;
        logic               negative;
        logic               status_bit;
        logic               is_last;
    } glyph_t;

    glyph_t             pending_glyphs[$];
    logic [RADIX_W-1:0] radix_q;
    logic               upper_q;
    logic [LIMIT_W-1:0] limit_q;
    int                 err_count;

    function automatic logic [CHAR_W-1:0] ascii_digit(input int d, input logic upper);
        if (d > 9)
            return CHAR_W'(d - 10) + (upper ? CHAR_UPPER : CHAR_LOWER);
        return CHAR_W'(d) + CHAR_ZERO;
    endfunction

    task automatic spell_value(input logic [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] mag;
        logic [VALUE_WIDTH-1:0] base;
        logic                   neg;
        int                     digs[MAX_DIGITS];
        int                     n;
        if (radix_q >= RADIX_MIN && radix_q <= RADIX_MAX)
            base = VALUE_WIDTH'(radix_q);
        else
            base = VALUE_WIDTH'(RADIX_DEFAULT);
        neg = v[VALUE_WIDTH-1];
        if (!neg && v > {1'b0, limit_q})
        begin
            pending_glyphs.push_back('{CHAR_NONE, '0, 1'b0, STATUS_RANGE, 1'b1});
        end
        else
        begin
            mag = neg ? -v : v;
            n = 0;
            while (n == 0 || (mag != 0 && n < MAX_DIGITS))
            begin
                digs[n] = int'(mag % base);
                mag = mag / base;
                n++;
            end
            if (neg)
                pending_glyphs.push_back('{CHAR_MINUS, COUNT_W'(n), 1'b1, STATUS_OK, 1'b0});
            for (int i = n - 1; i >= 0; i--)
                pending_glyphs.push_back('{ascii_digit(digs[i], upper_q), COUNT_W'(n), neg,
                                           STATUS_OK, i == 0});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        glyph_t want;
        if (!rst_n)
        begin
            radix_q = RADIX_DEFAULT;
            upper_q = 1'b0;
            limit_q = LIMIT_RESET;
            err_count = 0;
            pending_glyphs.delete();
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_RADIX: radix_q = cfg_data[RADIX_W-1:0];
                    REG_UPPER: upper_q = cfg_data[0];
                    REG_LIMIT: limit_q = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                spell_value(value);
            if (out_valid && !out_stall)
            begin
                if (pending_glyphs.size() == 0)
                begin
                    $error("unexpected transfer: character %0h status %0b", character, status);
                    err_count++;
                end
                else
                begin
                    want = pending_glyphs.pop_front();
                    if (character !== want.ch)
                    begin
                        $error("character: expected %0h, actual %0h", want.ch, character);
                        err_count++;
                    end
                    if (digit_count !== want.count)
                    begin
                        $error("digit_count: expected %0d, actual %0d", want.count, digit_count);
                        err_count++;
                    end
                    if (is_negative !== want.negative)
                    begin
                        $error("is_negative: expected %0b, actual %0b", want.negative,
                               is_negative);
                        err_count++;
                    end
                    if (status !== want.status_bit)
                    begin
                        $error("status: expected %0b, actual %0b", want.status_bit, status);
                        err_count++;
                    end
                    if (last !== want.is_last)
                    begin
                        $error("last: expected %0b, actual %0b", want.is_last, last);
                        err_count++;
                    end
                end
            end
            errors <= err_count;
            pending <= pending_glyphs.size();
        end
    end

endmodule

// File: tb/tb_integer_to_radix_digits.sv
// Top of the integer_to_radix_digits bench: clock, reset, value and register
// stimulus with random idling on both channels, and the final verdict.
// Depends on itrd_pkg, itrd_digit_checker and the integer_to_radix_digits RTL.
module tb_integer_to_radix_digits;
    import itrd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;
    localparam logic [LIMIT_W-1:0]   LIMIT_FULL = '1;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [VALUE_WIDTH-1:0] value = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [CHAR_W-1:0]             character;
    logic [COUNT_W-1:0]            digit_count;
    logic                          is_negative;
    logic                          status;
    logic                          last;
    logic                          cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;
    int                            errors;
    int                            pending;
    int                            send_idle = 10;
    int                            recv_idle = 64;

    integer_to_radix_digits DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .value(value),
        .out_valid(out_valid), .out_stall(out_stall), .character(character),
        .digit_count(digit_count), .is_negative(is_negative), .status(status),
        .last(last),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    itrd_digit_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .value(value),
        .out_valid(out_valid), .out_stall(out_stall), .character(character),
        .digit_count(digit_count), .is_negative(is_negative), .status(status),
        .last(last),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle);

    // call at a falling edge; returns at the falling edge after the transfer
    task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drain all results, then write every register
    task automatic configure(input logic [RADIX_W-1:0] r, input logic u,
                             input logic [LIMIT_W-1:0] lim);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_RADIX;
        cfg_data <= CFG_DATA_W'(r);
        @(negedge clk);
        cfg_index <= REG_UPPER;
        cfg_data <= CFG_DATA_W'(u);
        @(negedge clk);
        cfg_index <= REG_LIMIT;
        cfg_data <= lim;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [VALUE_WIDTH-1:0] pick_value(input logic [LIMIT_W-1:0] lim);
        logic [VALUE_WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom();
            2:
            begin
                v = $urandom_range(0, 1000);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            3: v = {1'b0, lim} + $urandom_range(0, 2) - 1;
            4: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default:
            begin
                v = $urandom_range(0, lim);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    initial
    begin
        #30_000_000;
        $display("integer_to_radix_digits test failed");
        $finish;
    end

    initial
    begin
        logic [RADIX_W-1:0] r;
        logic [LIMIT_W-1:0] lim;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_SPARE;
        cfg_data <= CFG_DATA_W'($urandom());
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);

        // reset settings: base ten, limit one million
        send_value(32'd0);
        send_value(32'd1);
        send_value(-32'sd1);
        send_value(32'd1_000_000);
        send_value(32'd1_000_001);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(-32'sd999_999);
        configure(6'd16, 1'b1, LIMIT_FULL);
        send_value(32'h7FFF_FFFF);
        send_value(-32'sh00AB_CDEF);
        send_value(32'd255);
        configure(6'd36, 1'b0, LIMIT_FULL);
        send_value(32'd35);
        send_value(32'h7FFF_FFFF);
        send_value(-32'sd36);
        configure(6'd2, 1'b1, LIMIT_FULL);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'd5);
        configure(6'd0, 1'b1, LIMIT_FULL);
        send_value(32'd123_456);
        configure(6'd1, 1'b0, '0);
        send_value(32'd0);
        send_value(32'd1);
        send_value(-32'sd7);
        configure(6'd63, 1'b1, 31'd12_345);
        send_value(32'd12_345);
        send_value(32'd12_346);
        configure(6'd37, 1'b0, LIMIT_FULL);
        send_value(32'hFFFF_FFFF);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 10 : (ph == 1) ? 64 : 0;
            recv_idle = (ph == 0) ? 64 : (ph == 1) ? 10 : 0;
            for (int g = 0; g < 5; g++)
            begin
                r = RADIX_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                          : $urandom_range(2, 36));
                case ($urandom_range(0, 5))
                    0, 1, 2: lim = LIMIT_FULL;
                    3: lim = LIMIT_W'($urandom());
                    4: lim = LIMIT_W'($urandom_range(0, 5000));
                    default: lim = LIMIT_RESET;
                endcase
                configure(r, 1'($urandom_range(0, 1)), lim);
                repeat (20)
                    send_value(pick_value(lim));
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("integer_to_radix_digits test passed");
        else
            $display("integer_to_radix_digits test failed");
        $finish;
    end

endmodule
